/* src/rhc_pkg.sv */
// Shared types and constants for the RGB to HSV converter.
// Used by rgb_to_hsv_converter_core; no dependencies.
package rhc_pkg;

  localparam int ChanW     = 8;
  localparam int HueW      = 16;
  localparam int HueNumW   = 11;  // base*d + diff and 6*d both stay below 1536
  localparam int HueBitsPerStage = 2;
  localparam int DivStages = HueW / HueBitsPerStage;  // 8 stages, one saturation bit each
  localparam int InDataW   = 4 * ChanW;
  localparam int OutDataW  = HueW + 3 * ChanW;

  // Which channel holds the maximum (red wins ties, then green)
  typedef enum logic [1:0] {
    SECT_RED   = 2'b00,
    SECT_GREEN = 2'b01,
    SECT_BLUE  = 2'b10
  } sect_t;

  // Divider pipeline word
  typedef struct packed {
    logic [HueNumW-1:0] hrem;   // hue partial remainder
    logic [HueNumW-1:0] hdiv;   // 6*d
    logic [HueW-1:0]    hq;     // hue quotient bits so far
    logic [ChanW-1:0]   srem;   // saturation partial remainder
    logic [ChanW-1:0]   sbits;  // low numerator bits still to shift in
    logic [ChanW-1:0]   sdiv;   // max channel
    logic [ChanW-1:0]   sq;     // saturation quotient bits so far
    logic [ChanW-1:0]   value;
    logic [ChanW-1:0]   alpha;
    logic               hzero;  // gray pixel
    logic               szero;  // black pixel
  } div_t;

endpackage

/* src/rgb_to_hsv_converter_core.sv */
// RGB to HSV converter core: stream in, stream out, fully pipelined.
// Depends on rhc_pkg.
//
// Takes one RGBA pixel per clock and returns value (max channel), saturation
// floor(255*(max-min)/max) and hue in 65536 units per turn, alpha copied.
// The pipeline runs from input transaction to output valid: one stage finds
// max/min and the hue sector, one forms numerators and divisors, eight restoring
// divider stages retire two hue bits and one saturation bit each, and the last
// is the output register. Throughput is one pixel per clock; when the output is
// stalled the whole pipeline holds, and empty output slots still let pixels in.
module rgb_to_hsv_converter_core
  import rhc_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [InDataW-1:0]  s_axis_tdata,   // red[7:0], green[15:8], blue[23:16], alpha[31:24]
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [OutDataW-1:0] m_axis_tdata    // hue[15:0], saturation[23:16], value[31:24],
                                              // alpha_out[39:32]
);

  logic ce;
  assign ce = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = ce;

  // ---------------- stage 1: max, min, sector ----------------
  logic [ChanW-1:0] in_r, in_g, in_b, in_a;
  logic [ChanW-1:0] mx_c, mn_c;
  sect_t            sect_c;

  assign in_r = s_axis_tdata[ChanW-1:0];
  assign in_g = s_axis_tdata[2*ChanW-1:ChanW];
  assign in_b = s_axis_tdata[3*ChanW-1:2*ChanW];
  assign in_a = s_axis_tdata[4*ChanW-1:3*ChanW];

  always_comb begin
    if (in_r >= in_g && in_r >= in_b) begin
      sect_c = SECT_RED;
      mx_c   = in_r;
    end else if (in_g >= in_b) begin
      sect_c = SECT_GREEN;
      mx_c   = in_g;
    end else begin
      sect_c = SECT_BLUE;
      mx_c   = in_b;
    end
    mn_c = in_r;
    if (in_g < mn_c) mn_c = in_g;
    if (in_b < mn_c) mn_c = in_b;
  end

  logic             v1;
  logic [ChanW-1:0] r1, g1, b1, a1, mx1, mn1;
  sect_t            sect1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (ce) begin
      v1 <= s_axis_tvalid;
    end
    if (ce) begin
      r1    <= in_r;
      g1    <= in_g;
      b1    <= in_b;
      a1    <= in_a;
      mx1   <= mx_c;
      mn1   <= mn_c;
      sect1 <= sect_c;
    end
  end

  // ---------------- stage 2: numerators and divisors ----------------
  logic [ChanW-1:0]   d2;
  logic [HueNumW-1:0] dw, num_c;
  logic [2*ChanW-1:0] satnum_c;
  div_t               setup_c;

  always_comb begin
    d2 = mx1 - mn1;
    dw = {{(HueNumW-ChanW){1'b0}}, d2};
    // sums wrap mod 2^11; the true numerator lies in [0, 6d)
    case (sect1)
      SECT_RED: begin
        num_c = {{(HueNumW-ChanW){1'b0}}, g1} - {{(HueNumW-ChanW){1'b0}}, b1};
        if (g1 < b1) num_c = num_c + (dw << 2) + (dw << 1);
      end
      SECT_GREEN: begin
        num_c = (dw << 1) + {{(HueNumW-ChanW){1'b0}}, b1}
              - {{(HueNumW-ChanW){1'b0}}, r1};
      end
      SECT_BLUE: begin
        num_c = (dw << 2) + {{(HueNumW-ChanW){1'b0}}, r1}
              - {{(HueNumW-ChanW){1'b0}}, g1};
      end
      default: begin
        num_c = '0;
      end
    endcase
    satnum_c = {d2, {ChanW{1'b0}}} - {{ChanW{1'b0}}, d2};  // 255*d

    setup_c.hrem  = num_c;
    setup_c.hdiv  = (dw << 2) + (dw << 1);
    setup_c.hq    = '0;
    // 255*d < 256*max, so the high byte is already below the divisor
    setup_c.srem  = satnum_c[2*ChanW-1:ChanW];
    setup_c.sbits = satnum_c[ChanW-1:0];
    setup_c.sdiv  = mx1;
    setup_c.sq    = '0;
    setup_c.value = mx1;
    setup_c.alpha = a1;
    setup_c.hzero = (d2 == '0);
    setup_c.szero = (mx1 == '0);
  end

  // ---------------- stages 3..10: restoring division ----------------
  logic [DivStages:0] dv_vld;
  div_t               dv      [DivStages+1];
  div_t               dv_next [DivStages];

  always_comb begin
    for (int i = 0; i < DivStages; i++) begin
      logic [HueNumW:0] ht;
      logic [ChanW:0]   st;
      dv_next[i] = dv[i];
      for (int k = 0; k < HueBitsPerStage; k++) begin
        ht = {dv_next[i].hrem, 1'b0};
        if (ht >= {1'b0, dv_next[i].hdiv}) begin
          ht = ht - {1'b0, dv_next[i].hdiv};
          dv_next[i].hq = {dv_next[i].hq[HueW-2:0], 1'b1};
        end else begin
          dv_next[i].hq = {dv_next[i].hq[HueW-2:0], 1'b0};
        end
        dv_next[i].hrem = ht[HueNumW-1:0];
      end
      st = {dv[i].srem, dv[i].sbits[ChanW-1]};
      dv_next[i].sbits = {dv[i].sbits[ChanW-2:0], 1'b0};
      if (st >= {1'b0, dv[i].sdiv}) begin
        st = st - {1'b0, dv[i].sdiv};
        dv_next[i].sq = {dv[i].sq[ChanW-2:0], 1'b1};
      end else begin
        dv_next[i].sq = {dv[i].sq[ChanW-2:0], 1'b0};
      end
      dv_next[i].srem = st[ChanW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dv_vld <= '0;
    end else if (ce) begin
      dv_vld <= {dv_vld[DivStages-1:0], v1};
    end
    if (ce) begin
      dv[0] <= setup_c;
      for (int i = 0; i < DivStages; i++) begin
        dv[i+1] <= dv_next[i];
      end
    end
  end

  // ---------------- output register ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (ce) begin
      m_axis_tvalid <= dv_vld[DivStages];
    end
    if (ce) begin
      m_axis_tdata <= {dv[DivStages].alpha,
                       dv[DivStages].value,
                       dv[DivStages].szero ? {ChanW{1'b0}} : dv[DivStages].sq,
                       dv[DivStages].hzero ? {HueW{1'b0}} : dv[DivStages].hq};
    end
  end

endmodule

/* tb/sv/tb.sv */
// Self-checking testbench for rgb_to_hsv_converter_core.
// Predicts hue, saturation, value and alpha per pixel and checks the output stream in order.
// Depends on rhc_pkg and rgb_to_hsv_converter_core.
module tb;
  import rhc_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int SectorCount = 6;
  localparam int GreenBase   = 2;
  localparam int BlueBase    = 4;
  localparam int HueTurn     = 65536;
  localparam int FullScale   = 255;
  localparam int PipeDepth   = 11;
  localparam int IdlePct     = 29;
  localparam int MaxReports  = 10;

  // Field order matches the bus packing, lowest field last
  typedef struct packed {
    logic [ChanW-1:0] alpha;
    logic [ChanW-1:0] blue;
    logic [ChanW-1:0] green;
    logic [ChanW-1:0] red;
  } rgba_t;

  typedef struct packed {
    logic [ChanW-1:0] alpha;
    logic [ChanW-1:0] value;
    logic [ChanW-1:0] saturation;
    logic [HueW-1:0]  hue;
  } hsv_t;

  logic                clk;
  logic                rst;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata;
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [OutDataW-1:0] m_axis_tdata;

  hsv_t hsv_expected[$];
  bit   idle_en;
  int   pixels_sent;
  int   pixels_checked;
  int   mismatches;

  rgb_to_hsv_converter_core dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  function automatic hsv_t rgb_to_hsv(input rgba_t px);
    int   r, g, b, mx, mn, d, num;
    hsv_t res;
    r  = px.red;
    g  = px.green;
    b  = px.blue;
    mx = r;
    mn = r;
    if (g > mx) mx = g;
    if (b > mx) mx = b;
    if (g < mn) mn = g;
    if (b < mn) mn = b;
    d  = mx - mn;
    res.alpha      = px.alpha;
    res.value      = ChanW'(mx);
    res.saturation = '0;
    res.hue        = '0;
    if (mx != 0) res.saturation = ChanW'((FullScale * d) / mx);
    if (d != 0) begin
      // red wins ties, then green
      if (r == mx) begin
        num = g - b;
        if (g < b) num += SectorCount * d;
      end else if (g == mx) begin
        num = GreenBase * d + b - r;
      end else begin
        num = BlueBase * d + r - g;
      end
      res.hue = HueW'((longint'(num) * HueTurn) / (SectorCount * d));
    end
    return res;
  endfunction

  task automatic note_mismatch(input string msg);
    mismatches++;
    if (mismatches <= MaxReports) $display("%t mismatch: %s", $realtime, msg);
  endtask

  // Input transactions feed the predictor; output transactions are checked in order
  always @(posedge clk) begin : check_results
    hsv_t want;
    hsv_t got;
    if (!rst) begin
      if (s_axis_tvalid && s_axis_tready) hsv_expected.push_back(rgb_to_hsv(s_axis_tdata));
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata;
        if (hsv_expected.size() == 0) begin
          note_mismatch($sformatf("unexpected result %h", got));
        end else begin
          want = hsv_expected.pop_front();
          pixels_checked++;
          if (got.hue !== want.hue || got.saturation !== want.saturation ||
              got.value !== want.value || got.alpha !== want.alpha)
            note_mismatch($sformatf(
              "hue %h/%h sat %h/%h val %h/%h alpha %h/%h (expected/actual)",
              want.hue, got.hue, want.saturation, got.saturation,
              want.value, got.value, want.alpha, got.alpha));
        end
      end
    end
  end

  always @(negedge clk) begin
    if (rst) m_axis_tready <= 1'b0;
    else     m_axis_tready <= idle_en ? ($urandom_range(99) >= IdlePct) : 1'b1;
  end

  // Called at a falling edge; returns at the falling edge after the transaction
  task automatic send_pixel(input rgba_t px);
    while (idle_en && $urandom_range(99) < IdlePct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= px;
    do @(posedge clk); while (!s_axis_tready);
    pixels_sent++;
    @(negedge clk);
  endtask

  task automatic send_rgba(input int r, input int g, input int b, input int a);
    rgba_t px;
    px.red   = ChanW'(r);
    px.green = ChanW'(g);
    px.blue  = ChanW'(b);
    px.alpha = ChanW'(a);
    send_pixel(px);
  endtask

  // Mostly uniform, with skews toward near-gray, tied maxima and dark pixels
  function automatic rgba_t random_pixel();
    rgba_t       px;
    int unsigned kind;
    px   = $urandom;
    kind = $urandom_range(99);
    if (kind < 20) begin
      px.green = px.red ^ ChanW'($urandom_range(3));
      px.blue  = px.red ^ ChanW'($urandom_range(3));
    end else if (kind < 32) begin
      case ($urandom_range(2))
        0:       px.green = px.red;
        1:       px.blue  = px.green;
        default: px.blue  = px.red;
      endcase
    end else if (kind < 40) begin
      px.red   &= 8'h07;
      px.green &= 8'h07;
      px.blue  &= 8'h07;
    end
    return px;
  endfunction

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    do @(negedge clk); while (hsv_expected.size() != 0);
  endtask

  task automatic test_corner_pixels();
    send_rgba(0, 0, 0, 0);          // black
    send_rgba(255, 255, 255, 255);  // white
    send_rgba(128, 128, 128, 8'hAA); // gray
    send_rgba(255, 0, 0, 8'h55);
    send_rgba(0, 255, 0, 0);
    send_rgba(0, 0, 255, 255);
    send_rgba(255, 255, 0, 1);      // red/green tie
    send_rgba(0, 255, 255, 2);      // green/blue tie
    send_rgba(255, 0, 255, 3);      // red/blue tie
    send_rgba(255, 0, 1, 4);        // red max, green below blue: hue wraps near a full turn
    send_rgba(255, 200, 10, 5);
    send_rgba(30, 200, 100, 6);
    send_rgba(100, 20, 250, 7);
    send_rgba(255, 254, 254, 8);    // smallest spread
    send_rgba(1, 0, 0, 9);
    send_rgba(0, 0, 1, 10);
    send_rgba(0, 1, 1, 11);
    send_rgba(2, 1, 2, 12);
  endtask

  task automatic test_random_pixels(input int count);
    idle_en = 1'b1;
    repeat (count) send_pixel(random_pixel());
  endtask

  task automatic test_back_to_back(input int count);
    idle_en = 1'b0;
    repeat (count) send_pixel(random_pixel());
    idle_en = 1'b1;
  endtask

  task automatic test_drain_and_resume(input int count);
    idle_en = 1'b1;
    repeat (count / 2) send_pixel(random_pixel());
    wait_drained();
    repeat (count - count / 2) send_pixel(random_pixel());
  endtask

  initial begin
    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    idle_en       = 1'b1;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_corner_pixels();
    test_random_pixels(600);
    test_back_to_back(250);
    test_drain_and_resume(250);
    wait_drained();
    repeat (2 * PipeDepth + 8) @(posedge clk);
    if (hsv_expected.size() != 0)
      note_mismatch($sformatf("%0d results never arrived", hsv_expected.size()));
    $display("Sent %0d pixels, checked %0d: corner colors, tied maxima, random and skewed",
             pixels_sent, pixels_checked);
    $display("mixes, back-to-back and drained stretches; %0d mismatches", mismatches);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #3_000_000;
    $display("Timeout with %0d results outstanding", hsv_expected.size());
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
